[rtl/kwc_pkg.sv]
// kwc_pkg: shared types and constants for the keyword occurrence counter
// no dependencies; used by kwc_hist_cell, kwc_slot_cell and the top level
`default_nettype none

package kwc_pkg;

    // symbol alphabet: a-z = 0..25, '1'-'9' = 26..34, '0' = 35
    localparam int SYM_W        = 6;
    localparam int KW_LEN_W     = 4;
    localparam int KW_SYMS      = 10;
    localparam int KW_REG_W     = 60;
    localparam int KW_EXT_W     = KW_LEN_W + KW_SYMS * SYM_W;
    localparam int CFG_INDEX_W  = 3;
    localparam int SLOT_INDEX_W = 3;
    localparam int COUNT_OUT_W  = 10;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 16;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_ONE     = 8'h31;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;
    localparam logic [SYM_W-1:0] SYM_DIGIT_BASE = 6'd26;
    localparam logic [SYM_W-1:0] SYM_DIGIT_ZERO = 6'd35;

    typedef logic [SYM_W-1:0] sym_t;

    // per-cycle control shared by the history row and the slot cells
    typedef struct packed {
        logic shift;   // a kept symbol enters the history
        logic clear;   // end of message: drop history and counts
    } hist_ctl_t;

endpackage

`default_nettype wire

[rtl/kwc_hist_cell.sv]
// kwc_hist_cell: one stage of the symbol history row
// depends on kwc_pkg
`default_nettype none

module kwc_hist_cell (
    input  wire               aclk,
    input  wire               aresetn,
    input  kwc_pkg::hist_ctl_t ctl,
    input  kwc_pkg::sym_t     sym_in,
    input  wire               vld_in,
    output kwc_pkg::sym_t     sym_out,
    output logic              vld_out,
    output kwc_pkg::sym_t     sym_shift,
    output logic              vld_shift
);

    kwc_pkg::sym_t sym_reg, sym_next;
    logic          vld_reg, vld_next;

    // value after this cycle's shift, before the end-of-message clear
    always_comb begin
        sym_shift = ctl.shift ? sym_in : sym_reg;
        vld_shift = ctl.shift ? vld_in : vld_reg;
        sym_next  = ctl.clear ? '0 : sym_shift;
        vld_next  = ctl.clear ? 1'b0 : vld_shift;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sym_reg <= '0;
            vld_reg <= 1'b0;
        end else begin
            sym_reg <= sym_next;
            vld_reg <= vld_next;
        end
    end

    assign sym_out = sym_reg;
    assign vld_out = vld_reg;

endmodule

`default_nettype wire

[rtl/kwc_slot_cell.sv]
// kwc_slot_cell: one keyword slot, holding its keyword register and its count
// depends on kwc_pkg; compares against the shifted history row
`default_nettype none

module kwc_slot_cell #(
    parameter int MAX_KEYWORD_LEN = 10,
    parameter int COUNT_BITS      = 10
) (
    input  wire                                        aclk,
    input  wire                                        aresetn,
    input  kwc_pkg::hist_ctl_t                         ctl,
    input  wire                                        wr_en,
    input  wire  [kwc_pkg::KW_REG_W-1:0]               wr_data,
    input  kwc_pkg::sym_t [MAX_KEYWORD_LEN-1:0]        hist_sym,
    input  wire  [MAX_KEYWORD_LEN-1:0]                 hist_vld,
    output logic [COUNT_BITS-1:0]                      count_upd
);

    logic [kwc_pkg::KW_REG_W-1:0] kw_reg;
    logic [COUNT_BITS-1:0]        cnt_reg, cnt_next;
    logic [kwc_pkg::KW_EXT_W-1:0] kw_ext;
    logic [kwc_pkg::KW_LEN_W-1:0] kw_len;
    logic [kwc_pkg::KW_LEN_W-1:0] k_idx;
    kwc_pkg::sym_t                kw_sym [kwc_pkg::KW_SYMS];
    logic                         hit;

    // newest history entry lines up with the keyword's last symbol
    always_comb begin
        kw_ext = {{(kwc_pkg::KW_EXT_W - kwc_pkg::KW_REG_W){1'b0}}, kw_reg};
        kw_len = kw_ext[kwc_pkg::KW_LEN_W-1:0];
        for (int k = 0; k < kwc_pkg::KW_SYMS; k++) begin
            kw_sym[k] = kw_ext[kwc_pkg::KW_LEN_W + kwc_pkg::SYM_W*k +: kwc_pkg::SYM_W];
        end
        hit   = (kw_len != '0) && (kw_len <= kwc_pkg::KW_LEN_W'(MAX_KEYWORD_LEN));
        k_idx = '0;
        for (int j = 0; j < MAX_KEYWORD_LEN; j++) begin
            if (kwc_pkg::KW_LEN_W'(j) < kw_len) begin
                k_idx = kw_len - kwc_pkg::KW_LEN_W'(j) - kwc_pkg::KW_LEN_W'(1);
                if (!hist_vld[j] || (hist_sym[j] != kw_sym[k_idx])) begin
                    hit = 1'b0;
                end
            end
        end
    end

    // saturating count
    always_comb begin
        count_upd = cnt_reg;
        if (ctl.shift && hit && !(&cnt_reg)) begin
            count_upd = cnt_reg + COUNT_BITS'(1);
        end
        cnt_next = ctl.clear ? '0 : count_upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kw_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (wr_en) begin
                kw_reg <= wr_data;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/keyword_occurrence_counter.sv]
// keyword_occurrence_counter: top level, byte stream in, per-slot counts out
// depends on kwc_pkg, kwc_hist_cell and kwc_slot_cell
`default_nettype none

// Takes one message byte per transfer on the s_ stream (tlast marks the last
// byte of a message) and counts, for each of KEYWORD_SLOTS keywords, how many
// times it occurs in the message, overlaps included. Letters are folded to
// lower case and anything that is not a letter or digit is skipped. A byte is
// taken every cycle unless held off as below: the history is a row of cells
// that shifts on each kept symbol, and every slot cell compares its keyword
// against the whole row in the same cycle. On the end-of-message byte the
// counts are copied into a report buffer and cleared, so the next message can
// stream in at once. The report then leaves on the m_ stream one transfer per
// cycle while m_tready is high. It holds one result per slot with a nonzero
// count in slot order, or one empty result (tuser set) if nothing matched;
// tlast marks the final one. A second end-of-message byte is held off
// (s_tready low) until the last result of the previous report moves into the
// output register, other bytes keep flowing. Keywords are written through the
// cfg_ port (index = slot) while the block is idle, which the user must ensure
// as the block does not enforce it; writes always complete.
module keyword_occurrence_counter #(
    parameter int KEYWORD_SLOTS   = 8,
    parameter int MAX_KEYWORD_LEN = 10,
    parameter int COUNT_BITS      = 10
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // message bytes
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [kwc_pkg::IN_TDATA_W-1:0]      s_tdata,   // [7:0] char_code
    input  wire                                 s_tlast,   // end_of_message
    // results
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [kwc_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [2:0] slot_index, [12:3] match_count
    output logic                                m_tuser,   // [0] is_empty
    output logic                                m_tlast,   // last_result
    // keyword writes
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [kwc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire  [kwc_pkg::KW_REG_W-1:0]        cfg_data
);

    // byte to symbol map, {kept, symbol}
    function automatic logic [kwc_pkg::SYM_W:0] map_byte(input logic [7:0] b);
        logic [7:0]              c;
        logic [kwc_pkg::SYM_W:0] r;
        c = b;
        r = '0;
        if (c >= kwc_pkg::CHAR_UPPER_A && c <= kwc_pkg::CHAR_UPPER_Z) begin
            c = c + kwc_pkg::CASE_OFFSET;
        end
        if (c >= kwc_pkg::CHAR_LOWER_A && c <= kwc_pkg::CHAR_LOWER_Z) begin
            r = {1'b1, kwc_pkg::SYM_W'(c - kwc_pkg::CHAR_LOWER_A)};
        end else if (c >= kwc_pkg::CHAR_ONE && c <= kwc_pkg::CHAR_NINE) begin
            r = {1'b1, kwc_pkg::SYM_W'(c - kwc_pkg::CHAR_ONE) + kwc_pkg::SYM_DIGIT_BASE};
        end else if (c == kwc_pkg::CHAR_ZERO) begin
            r = {1'b1, kwc_pkg::SYM_DIGIT_ZERO};
        end
        return r;
    endfunction

    // input side
    logic                    in_xfer;
    logic                    eom_xfer;
    logic [kwc_pkg::SYM_W:0] mapped;
    kwc_pkg::sym_t           new_sym;
    kwc_pkg::hist_ctl_t      ctl;

    // history row
    kwc_pkg::sym_t [MAX_KEYWORD_LEN-1:0] hist_q;
    logic [MAX_KEYWORD_LEN-1:0]          hist_vq;
    kwc_pkg::sym_t [MAX_KEYWORD_LEN-1:0] hist_s;
    logic [MAX_KEYWORD_LEN-1:0]          hist_vs;

    // slot counts after this cycle's update
    logic [COUNT_BITS-1:0] count_upd [KEYWORD_SLOTS];

    // report buffer
    logic                     rep_busy_reg, rep_busy_next;
    logic                     rep_empty_reg, rep_empty_next;
    logic [KEYWORD_SLOTS-1:0] rep_mask_reg, rep_mask_next;
    logic [COUNT_BITS-1:0]    rep_count_reg [KEYWORD_SLOTS];

    // emission
    logic                                out_load;
    logic                                emit;
    logic                                rep_finish;
    logic [KEYWORD_SLOTS-1:0]            pick_hot;
    logic [KEYWORD_SLOTS-1:0]            rest_mask;
    logic [kwc_pkg::SLOT_INDEX_W-1:0]    pick_idx;
    logic [COUNT_BITS-1:0]               pick_count;
    logic [COUNT_BITS+kwc_pkg::COUNT_OUT_W-1:0] pick_ext;

    // output register
    logic                             m_valid_reg, m_valid_next;
    logic [kwc_pkg::OUT_TDATA_W-1:0]  m_data_reg, m_data_next;
    logic                             m_user_reg, m_user_next;
    logic                             m_last_reg, m_last_next;

    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------------
    // input acceptance: only an end-of-message byte waits for the report
    // ---------------------------------------------------------------------
    assign s_tready = !s_tlast || !rep_busy_reg || rep_finish;
    assign in_xfer  = s_tvalid && s_tready;
    assign eom_xfer = in_xfer && s_tlast;

    always_comb begin
        mapped    = map_byte(s_tdata);
        new_sym   = mapped[kwc_pkg::SYM_W-1:0];
        ctl.shift = in_xfer && mapped[kwc_pkg::SYM_W];
        ctl.clear = eom_xfer;
    end

    // ---------------------------------------------------------------------
    // history row: newest symbol in cell zero
    // ---------------------------------------------------------------------
    for (genvar i = 0; i < MAX_KEYWORD_LEN; i++) begin : g_hist
        kwc_pkg::sym_t sym_in;
        logic          vld_in;
        if (i == 0) begin : g_head
            assign sym_in = new_sym;
            assign vld_in = 1'b1;
        end else begin : g_body
            assign sym_in = hist_q[i-1];
            assign vld_in = hist_vq[i-1];
        end
        kwc_hist_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .sym_in    (sym_in),
            .vld_in    (vld_in),
            .sym_out   (hist_q[i]),
            .vld_out   (hist_vq[i]),
            .sym_shift (hist_s[i]),
            .vld_shift (hist_vs[i])
        );
    end

    // ---------------------------------------------------------------------
    // keyword slots
    // ---------------------------------------------------------------------
    for (genvar s = 0; s < KEYWORD_SLOTS; s++) begin : g_slot
        logic wr_en;
        assign wr_en = cfg_valid && (cfg_index == kwc_pkg::CFG_INDEX_W'(s));
        kwc_slot_cell #(
            .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN),
            .COUNT_BITS      (COUNT_BITS)
        ) u_slot (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .wr_en     (wr_en),
            .wr_data   (cfg_data),
            .hist_sym  (hist_s),
            .hist_vld  (hist_vs),
            .count_upd (count_upd[s])
        );
    end

    // ---------------------------------------------------------------------
    // report: lowest pending slot goes out whenever the output register frees
    // ---------------------------------------------------------------------
    assign out_load = !m_valid_reg || m_tready;
    assign emit     = rep_busy_reg && out_load;

    always_comb begin
        pick_hot   = '0;
        pick_idx   = '0;
        pick_count = '0;
        for (int s = KEYWORD_SLOTS - 1; s >= 0; s--) begin
            if (rep_mask_reg[s]) begin
                pick_hot = '0;
                pick_hot[s] = 1'b1;
                pick_idx = kwc_pkg::SLOT_INDEX_W'(s);
            end
        end
        for (int s = 0; s < KEYWORD_SLOTS; s++) begin
            if (pick_hot[s]) begin
                pick_count = rep_count_reg[s];
            end
        end
        rest_mask = rep_mask_reg & ~pick_hot;
        pick_ext  = {{kwc_pkg::COUNT_OUT_W{1'b0}}, pick_count};
    end

    assign rep_finish = emit && (rep_empty_reg || (rest_mask == '0));

    always_comb begin
        rep_busy_next  = rep_busy_reg;
        rep_empty_next = rep_empty_reg;
        rep_mask_next  = rep_mask_reg;
        if (eom_xfer) begin
            rep_busy_next = 1'b1;
            for (int s = 0; s < KEYWORD_SLOTS; s++) begin
                rep_mask_next[s] = (count_upd[s] != '0);
            end
            rep_empty_next = (rep_mask_next == '0);
        end else if (emit) begin
            rep_mask_next = rest_mask;
            if (rep_finish) begin
                rep_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rep_busy_reg  <= 1'b0;
            rep_empty_reg <= 1'b0;
            rep_mask_reg  <= '0;
        end else begin
            rep_busy_reg  <= rep_busy_next;
            rep_empty_reg <= rep_empty_next;
            rep_mask_reg  <= rep_mask_next;
        end
    end

    // snapshot of the counts, payload only
    always_ff @(posedge aclk) begin
        if (eom_xfer) begin
            for (int s = 0; s < KEYWORD_SLOTS; s++) begin
                rep_count_reg[s] <= count_upd[s];
            end
        end
    end

    // ---------------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_last_next  = rep_finish;
            m_user_next  = rep_empty_reg;
            if (rep_empty_reg) begin
                m_data_next = '0;
            end else begin
                m_data_next = kwc_pkg::OUT_TDATA_W'(
                    {pick_ext[kwc_pkg::COUNT_OUT_W-1:0], pick_idx});
            end
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
        else $error("empty result not alone or carries data");

    a_eom_starts_report: assert property (@(posedge aclk) disable iff (!aresetn)
        eom_xfer |=> rep_busy_reg)
        else $error("end of message did not start a report");

    a_report_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        rep_busy_reg |-> (rep_empty_reg || (rep_mask_reg != '0)))
        else $error("report busy with nothing to send");

    a_eom_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (rep_busy_reg && !rep_finish && s_tvalid && s_tlast) |-> !s_tready)
        else $error("end of message taken over a pending report");

endmodule

`default_nettype wire
